[hdl/xorshift_bounded_random_unit_assert.svh]
// ----------------------------------------------------------------------------
// xorshift bounded random unit assertion macros
// concurrent assertion shorthands shared by the checker
// ----------------------------------------------------------------------------
`ifndef XORSHIFT_BOUNDED_RANDOM_UNIT_ASSERT_SVH
`define XORSHIFT_BOUNDED_RANDOM_UNIT_ASSERT_SVH

// same-cycle implication, masked during reset
`define XBR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xbr assertion failed");

// next-cycle implication, masked during reset
`define XBR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xbr assertion failed");

// next-cycle implication that also holds across reset
`define XBR_ASSERT_NXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("xbr assertion failed");

`endif

[hdl/xbr_pkg.sv]
// ----------------------------------------------------------------------------
// xbr_pkg
// shared types and constants of the xorshift bounded random unit
// ----------------------------------------------------------------------------
package xbr_pkg;

  localparam int OP_W   = 2;
  localparam int RAW_W  = 32;
  localparam int SPAN_W = RAW_W + 1;
  localparam int SHORT_W = 16;
  localparam int BYTE_W  = 8;

  localparam logic [RAW_W-1:0] START_A = 32'd123456789;
  localparam logic [RAW_W-1:0] START_B = 32'd362436069;
  localparam logic [RAW_W-1:0] START_C = 32'd521288629;
  localparam logic [RAW_W-1:0] START_D = 32'd88675123;
  localparam logic [BYTE_W-1:0] BYTE_FLIP = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_LONG = 2'd0,
    OP_WORD = 2'd1,
    OP_BYTE = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // one classified request: raw draw, modulus, offset and result width
  typedef struct packed {
    op_t               width;
    logic [RAW_W-1:0]  raw;
    logic [SPAN_W-1:0] span;
    logic [RAW_W-1:0]  low;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

endpackage

[hdl/xbr_req_if.sv]
// ----------------------------------------------------------------------------
// xbr_req_if
// request channel: operation and range bounds with valid/ready
// ----------------------------------------------------------------------------
interface xbr_req_if;
  import xbr_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [RAW_W-1:0]    range_low;
  logic [RAW_W-1:0]    range_high;

  modport source (output valid, operation, range_low, range_high, input ready);
  modport sink   (input valid, operation, range_low, range_high, output ready);
endinterface

[hdl/xbr_rsp_if.sv]
// ----------------------------------------------------------------------------
// xbr_rsp_if
// result channel: bounded random value with valid/ready
// ----------------------------------------------------------------------------
interface xbr_rsp_if;
  import xbr_pkg::*;

  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] value;

  modport source (output valid, value, input ready);
  modport sink   (input valid, value, output ready);
endinterface

[hdl/xbr_front.sv]
// ----------------------------------------------------------------------------
// xbr_front
// request intake: steps the generators and classifies each transaction
// ----------------------------------------------------------------------------
module xbr_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_wdata,
  input  logic                  q_full,
  xbr_req_if.sink               in_req,
  output xbr_pkg::push_t        push_o
);
  import xbr_pkg::*;

  logic [RAW_W-1:0]   la_r, lb_r, lc_r;
  logic [SHORT_W-1:0] sa_r, sb_r, sc_r, sd_r;

  logic [RAW_W-1:0]   seed_src;
  logic [RAW_W-1:0]   load_a, load_b, load_c, load_d;
  logic [RAW_W-1:0]   t1, t2, t3, lc_nxt;
  logic [SHORT_W-1:0] ts, sd_nxt;
  logic [RAW_W-1:0]   sd_wide;
  logic [RAW_W-1:0]   gap_long;
  logic [SHORT_W-1:0] gap_word;
  logic [BYTE_W-1:0]  gap_byte;
  op_t                op;
  logic               accept;
  job_t               job;

  assign in_req.ready = !q_full;
  assign accept       = in_req.valid && !q_full;
  assign op           = op_t'(in_req.operation);

  // reload values: reset behaves as a seed of zero
  assign seed_src = rst_n ? cfg_wdata : '0;
  assign load_a   = START_A + seed_src;
  assign load_b   = START_B + seed_src;
  assign load_c   = START_C + seed_src;
  assign load_d   = START_D + seed_src;

  // bound differences, each wrapping at its own width
  assign gap_long = in_req.range_high - in_req.range_low;
  assign gap_word = in_req.range_high[SHORT_W-1:0] - in_req.range_low[SHORT_W-1:0];
  assign gap_byte = in_req.range_high[BYTE_W-1:0] - in_req.range_low[BYTE_W-1:0];

  // 32-bit three-word step
  always_comb begin
    t1     = la_r ^ (la_r << 16);
    t2     = t1 ^ (t1 >> 5);
    t3     = t2 ^ (t2 << 1);
    lc_nxt = t3 ^ lb_r ^ lc_r;
  end

  // 16-bit four-word step; the d>>19 term is zero at this width
  always_comb begin
    ts      = sa_r ^ (sa_r << 11);
    sd_wide = {{(RAW_W-SHORT_W){1'b0}}, sd_r} >> 19;
    sd_nxt  = sd_r ^ sd_wide[SHORT_W-1:0] ^ ts ^ (ts >> 8);
  end

  always_comb begin
    job.width = op;
    case (op)
      OP_LONG: begin
        job.raw  = lc_nxt;
        job.span = {1'b0, gap_long} + SPAN_W'(1);
        job.low  = in_req.range_low;
      end
      OP_WORD: begin
        job.raw  = RAW_W'(sd_nxt);
        job.span = {{(SPAN_W-SHORT_W){1'b0}}, gap_word} + SPAN_W'(1);
        job.low  = RAW_W'(in_req.range_low[SHORT_W-1:0]);
      end
      OP_BYTE: begin
        job.raw  = RAW_W'(sd_nxt[BYTE_W-1:0] ^ BYTE_FLIP);
        job.span = {{(SPAN_W-BYTE_W){1'b0}}, gap_byte} + SPAN_W'(1);
        job.low  = RAW_W'(in_req.range_low[BYTE_W-1:0]);
      end
      default: begin
        job.raw  = '0;
        job.span = SPAN_W'(1);
        job.low  = '0;
      end
    endcase
  end

  assign push_o.push = accept;
  assign push_o.job  = job;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      la_r <= load_a;
      lb_r <= load_b;
      lc_r <= load_c;
      sa_r <= load_a[SHORT_W-1:0];
      sb_r <= load_b[SHORT_W-1:0];
      sc_r <= load_c[SHORT_W-1:0];
      sd_r <= load_d[SHORT_W-1:0];
    end else if (accept) begin
      if (op == OP_LONG) begin
        la_r <= lb_r;
        lb_r <= lc_r;
        lc_r <= lc_nxt;
      end
      if (op == OP_WORD || op == OP_BYTE) begin
        sa_r <= sb_r;
        sb_r <= sc_r;
        sc_r <= sd_r;
        sd_r <= sd_nxt;
      end
    end
  end

endmodule

[hdl/xbr_fifo.sv]
// ----------------------------------------------------------------------------
// xbr_fifo
// short job queue between intake and remainder engine
// ----------------------------------------------------------------------------
module xbr_fifo #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  xbr_pkg::push_t  push_i,
  input  logic            pop,
  output logic            full,
  output xbr_pkg::head_t  head_o
);
  import xbr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full         = (cnt_r == CNT_W'(DEPTH));
  assign head_o.valid = (cnt_r != '0);
  assign head_o.job   = mem[rd_ptr_r];
  assign do_push      = push_i.push && !full;
  assign do_pop       = pop && head_o.valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        mem[wr_ptr_r] <= push_i.job;
        wr_ptr_r      <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

[hdl/xbr_back.sv]
// ----------------------------------------------------------------------------
// xbr_back
// bit-serial restoring remainder, offset add and result register
// ----------------------------------------------------------------------------
module xbr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  xbr_pkg::head_t  head_i,
  output logic            pop,
  xbr_rsp_if.source       out_rsp
);
  import xbr_pkg::*;

  localparam int CNT_W = $clog2(RAW_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(RAW_W - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_ADD,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RAW_W-1:0]  rem_r, raw_r, low_r, out_value_r;
  logic [SPAN_W-1:0] span_r;
  op_t               width_r;
  logic              out_valid_r;

  logic [SPAN_W-1:0] shifted, diff;
  logic [RAW_W-1:0]  rem_nxt, sum, value_nxt;

  assign pop           = (state_r == S_IDLE);
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.value = out_value_r;

  // one restoring step: shift in the next raw bit, subtract if it fits
  always_comb begin
    shifted = {rem_r, raw_r[RAW_W-1]};
    diff    = shifted - span_r;
    rem_nxt = (shifted >= span_r) ? diff[RAW_W-1:0] : shifted[RAW_W-1:0];
  end

  always_comb begin
    sum = low_r + rem_r;
    case (width_r)
      OP_WORD: value_nxt = RAW_W'(sum[SHORT_W-1:0]);
      OP_BYTE: value_nxt = RAW_W'(sum[BYTE_W-1:0]);
      default: value_nxt = sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (head_i.valid) begin
            raw_r   <= head_i.job.raw;
            span_r  <= head_i.job.span;
            low_r   <= head_i.job.low;
            width_r <= head_i.job.width;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          rem_r <= rem_nxt;
          raw_r <= raw_r << 1;
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == LAST_STEP) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          out_value_r <= value_nxt;
          out_valid_r <= 1'b1;
          state_r     <= S_DONE;
        end
        S_DONE: begin
          if (out_rsp.ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

[hdl/xorshift_bounded_random_unit.sv]
// an accepted request is queued, then loaded by the remainder engine, run
//   through the 32-step bit-serial remainder loop and the offset add, and
//   its result is registered; the engine takes no new job until that handoff
// up to QUEUE_DEPTH requests are taken while the remainder engine is busy
// reset: generator words load their start constants with a zero seed,
//   queue empty, result channel idle; no clearing pass
// ----------------------------------------------------------------------------
// xorshift_bounded_random_unit
// two xorshift generators feeding a bounded-range reduction stage
// ----------------------------------------------------------------------------
module xorshift_bounded_random_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // seed write: reloads every generator word
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  xbr_req_if.sink     in_req,
  xbr_rsp_if.source   out_rsp
);
  import xbr_pkg::*;

  push_t push;   // intake -> queue
  head_t head;   // queue head -> remainder engine
  logic  q_full;
  logic  pop;

  // intake: holds both generators, steps the one named by each transaction
  // and turns bounds into a modulus (33 bits so a full long span is 2^32)
  xbr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .in_req    (in_req),
    .push_o    (push)
  );

  // decouples intake from the slow remainder engine
  xbr_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_i (push),
    .pop    (pop),
    .full   (q_full),
    .head_o (head)
  );

  // remainder engine: one raw bit per cycle, then offset add and width wrap
  xbr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head_i  (head),
    .pop     (pop),
    .out_rsp (out_rsp)
  );

endmodule

[hdl/xbr_checker.sv]
// ----------------------------------------------------------------------------
// xbr_checker
// port-level checks of the xorshift bounded random unit
// ----------------------------------------------------------------------------
`include "xorshift_bounded_random_unit_assert.svh"

module xbr_checker #(
  parameter int CAPACITY = 3
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value
);

  localparam int PEND_W = $clog2(CAPACITY + 2);

  logic [PEND_W-1:0] pending_r;
  logic              in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   pending_r <= pending_r + PEND_W'(1);
        2'b01:   pending_r <= pending_r - PEND_W'(1);
        default: pending_r <= pending_r;
      endcase
    end
  end

  `XBR_ASSERT_NXT_ALWAYS(a_reset_quiet, !rst_n, !out_valid)
  `XBR_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value))
  `XBR_ASSERT_IMP(a_no_phantom, out_valid, pending_r != '0)
  `XBR_ASSERT_IMP(a_capacity, in_acc, pending_r < PEND_W'(CAPACITY))
  `XBR_ASSERT_IMP(a_ready_when_drained, pending_r == '0, in_ready)

endmodule

bind xorshift_bounded_random_unit xbr_checker #(
  .CAPACITY (QUEUE_DEPTH + 1)
) u_xbr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_req.valid),
  .in_ready  (in_req.ready),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .out_value (out_rsp.value)
);
